// ===== rtl/core/rgb_to_terminal_palette_index_core_assert.svh =====
// Assertion macros shared by the palette index core.
`ifndef RGB_TO_TERMINAL_PALETTE_INDEX_CORE_ASSERT_SVH
`define RGB_TO_TERMINAL_PALETTE_INDEX_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the core clock and muted during reset.
`define RTPI_ASSERT_IMPL(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Next-cycle implication, sampled on the core clock and muted during reset.
`define RTPI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== rtl/core/rtpi_pkg.sv =====
// Shared types, constants and color helpers for the palette index core.
`timescale 1ns / 1ps
`default_nettype none

package rtpi_pkg;

   localparam int DIST_W        = 18;   // 3 * 255^2 fits in 18 bits
   localparam int LEVEL_W       = 3;
   localparam int GRAY_W        = 5;
   localparam int SUM_W         = 10;
   localparam int SLOT_W        = 4;
   localparam int NUM_CELLS     = 16;

   localparam logic [7:0] CUBE_IDX_BASE = 8'd16;
   localparam logic [7:0] GRAY_IDX_BASE = 8'd232;
   localparam logic [7:0] INDEX_INIT    = 8'hff;
   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   localparam logic [7:0] ANSI_DIM      = 8'h80;
   localparam logic [7:0] ANSI_BRIGHT   = 8'hff;
   localparam logic [7:0] ANSI_LIGHT_GRAY = 8'hc0;
   localparam logic [7:0] ANSI_DARK_GRAY  = 8'h80;

   localparam logic [SLOT_W-1:0] SLOT_CUBE       = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_GRAY_LO    = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_GRAY_HI    = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_LIGHT_GRAY = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_DARK_GRAY  = 4'd8;

   // Gray step search: k0 = floor((sum - 24) / 30) by reciprocal multiply.
   localparam logic [SUM_W-1:0]  GRAY_SUM_OFFSET = 10'd24;
   localparam logic [10:0]       RECIP_30        = 11'd1093;
   localparam int                RECIP_SHIFT     = 15;
   localparam logic [GRAY_W-1:0] GRAY_K0_MAX     = 5'd22;

   typedef enum logic {
      MODE_256 = 1'b0,
      MODE_16  = 1'b1
   } mode_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      mode_type           mode;
      logic [LEVEL_W-1:0] cube_r;
      logic [LEVEL_W-1:0] cube_g;
      logic [LEVEL_W-1:0] cube_b;
      logic [GRAY_W-1:0]  gray_k;
      logic [DIST_W-1:0]  best_dist;
      logic [7:0]         best_index;
   } pipe_type;

   // Cube level n maps to 0 for n = 0, otherwise 40 * n + 55.
   function automatic logic [7:0] cube_level(input logic [LEVEL_W-1:0] n);
      logic [8:0] t;
      t = 9'(n) * 9'd40 + 9'd55;
      return (n == '0) ? 8'd0 : t[7:0];
   endfunction

   // Nearest cube level for one channel; a tie at a midpoint keeps the lower level.
   function automatic logic [LEVEL_W-1:0] nearest_level(input logic [7:0] c);
      logic [LEVEL_W-1:0] n;
      n = '0;
      if (c > 8'd47)  n = n + 3'd1;
      if (c > 8'd115) n = n + 3'd1;
      if (c > 8'd155) n = n + 3'd1;
      if (c > 8'd195) n = n + 3'd1;
      if (c > 8'd235) n = n + 3'd1;
      return n;
   endfunction

   // Gray step k has value 8 + 10 * k.
   function automatic logic [7:0] gray_level(input logic [GRAY_W-1:0] k);
      logic [8:0] t;
      t = 9'(k) * 9'd10 + 9'd8;
      return t[7:0];
   endfunction

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtpi_prep.sv =====
// Front stages: per-channel cube levels, channel sum and the gray step estimate.
`timescale 1ns / 1ps
`default_nettype none

module rtpi_prep
   import rtpi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire logic [7:0] in_red,
   input  wire logic [7:0] in_green,
   input  wire logic [7:0] in_blue,
   input  wire mode_type in_mode,
   output logic          out_valid,
   input  wire logic     out_stall,
   output pipe_type      out_data
);

   logic               s1_valid_ff, s1_valid_in;
   pipe_type           s1_data_ff;
   logic [SUM_W-1:0]   s1_sum_ff;
   logic               s1_stall, s2_stall;
   logic               s2_valid_ff, s2_valid_in;
   pipe_type           s2_data_ff, s2_data_in;
   logic [SUM_W-1:0]   offset_sum;
   logic [20:0]        scaled;
   logic [GRAY_W-1:0]  k_raw;

   assign s2_stall = s2_valid_ff && out_stall;
   assign s1_stall = s1_valid_ff && s2_stall;
   assign in_stall = s1_stall;

   assign s1_valid_in = s1_stall ? s1_valid_ff : in_valid;
   assign s2_valid_in = s2_stall ? s2_valid_ff : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage one: capture the pixel, its cube levels and the channel sum.
   always_ff @(posedge clock) begin
      if (in_valid && !s1_stall) begin
         s1_data_ff.red        <= in_red;
         s1_data_ff.green      <= in_green;
         s1_data_ff.blue       <= in_blue;
         s1_data_ff.mode       <= in_mode;
         s1_data_ff.cube_r     <= nearest_level(in_red);
         s1_data_ff.cube_g     <= nearest_level(in_green);
         s1_data_ff.cube_b     <= nearest_level(in_blue);
         s1_data_ff.gray_k     <= '0;
         s1_data_ff.best_dist  <= DIST_INIT;
         s1_data_ff.best_index <= INDEX_INIT;
         s1_sum_ff <= SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
      end
   end

   // Stage two: the nearest gray sits at step k0 or k0 + 1, with
   // k0 = floor((sum - 24) / 30) clamped so that k0 + 1 stays on the ramp.
   always_comb begin
      offset_sum = (s1_sum_ff >= GRAY_SUM_OFFSET) ? (s1_sum_ff - GRAY_SUM_OFFSET) : '0;
      scaled     = 21'(offset_sum) * 21'(RECIP_30);
      k_raw      = scaled[RECIP_SHIFT +: GRAY_W];
      s2_data_in = s1_data_ff;
      s2_data_in.gray_k = (k_raw > GRAY_K0_MAX) ? GRAY_K0_MAX : k_raw;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && !s2_stall) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rtpi_cell.sv =====
// One search cell: scores its palette candidate and keeps the nearer entry.
`timescale 1ns / 1ps
`default_nettype none

module rtpi_cell
   import rtpi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] slot,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire pipe_type          in_data,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output pipe_type               out_data
);

   logic              valid_ff, valid_in;
   pipe_type          data_ff, data_in;
   logic [7:0]        cand_r, cand_g, cand_b, cand_index, ansi_level;
   logic              cand_ok, take;
   logic [DIST_W-1:0] cand_dist;
   logic [GRAY_W-1:0] gray_k;

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   // Candidate color for this slot, chosen by the palette mode.
   always_comb begin
      cand_r     = '0;
      cand_g     = '0;
      cand_b     = '0;
      cand_index = '0;
      cand_ok    = 1'b0;
      gray_k     = in_data.gray_k;
      ansi_level = slot[3] ? ANSI_BRIGHT : ANSI_DIM;
      unique case (in_data.mode)
         MODE_16: begin
            cand_ok    = 1'b1;
            cand_index = 8'(slot);
            cand_r     = slot[0] ? ansi_level : 8'd0;
            cand_g     = slot[1] ? ansi_level : 8'd0;
            cand_b     = slot[2] ? ansi_level : 8'd0;
            if (slot == SLOT_LIGHT_GRAY) begin
               cand_r = ANSI_LIGHT_GRAY;
               cand_g = ANSI_LIGHT_GRAY;
               cand_b = ANSI_LIGHT_GRAY;
            end else if (slot == SLOT_DARK_GRAY) begin
               cand_r = ANSI_DARK_GRAY;
               cand_g = ANSI_DARK_GRAY;
               cand_b = ANSI_DARK_GRAY;
            end
         end
         MODE_256: begin
            if (slot == SLOT_CUBE) begin
               cand_ok    = 1'b1;
               cand_r     = cube_level(in_data.cube_r);
               cand_g     = cube_level(in_data.cube_g);
               cand_b     = cube_level(in_data.cube_b);
               cand_index = CUBE_IDX_BASE + 8'(in_data.cube_r) * 8'd36
                            + 8'(in_data.cube_g) * 8'd6 + 8'(in_data.cube_b);
            end else if (slot == SLOT_GRAY_LO || slot == SLOT_GRAY_HI) begin
               cand_ok = 1'b1;
               if (slot == SLOT_GRAY_HI) begin
                  gray_k = in_data.gray_k + 5'd1;
               end
               cand_r     = gray_level(gray_k);
               cand_g     = cand_r;
               cand_b     = cand_r;
               cand_index = GRAY_IDX_BASE + 8'(gray_k);
            end
         end
      endcase
   end

   // Equal distances go to the lower palette index.
   always_comb begin
      cand_dist = DIST_W'(sq_diff(in_data.red, cand_r))
                  + DIST_W'(sq_diff(in_data.green, cand_g))
                  + DIST_W'(sq_diff(in_data.blue, cand_b));
      take = cand_ok && ((cand_dist < in_data.best_dist) ||
                         ((cand_dist == in_data.best_dist) &&
                          (cand_index < in_data.best_index)));
      data_in = in_data;
      if (take) begin
         data_in.best_dist  = cand_dist;
         data_in.best_index = cand_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_terminal_palette_index_core.sv =====
// Top level of the RGB to terminal palette index core.
// An accepted input word passes the prep stages and every cell register to the rsp port.
// Throughput: one word per cycle while rsp_stall is low; every stage holds at most one word.
// Reset: synchronous, active high; empties the pipeline and sets the mode to 256 colors.
// The mode register is sampled into each word as it enters.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_terminal_palette_index_core_assert.svh"

module rgb_to_terminal_palette_index_core
   import rtpi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_palette_index
);

   // The palette mode register. The user must change it only while the core is idle; the
   // block does not enforce this, and each word carries its own copy through the pipeline.
   mode_type mode_ff, mode_in;

   assign mode_in = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_256;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Links between neighbors: link n feeds cell n, and the last link is the
   // output register. Every stage stalls only when it is full and its
   // downstream neighbor stalls, so bubbles are squeezed out of the chain.
   pipe_type link_data  [NUM_CELLS+1];
   logic     link_valid [NUM_CELLS+1];
   logic     link_stall [NUM_CELLS+1];

   // The front end works out the nearest cube level per channel and the
   // bracketing gray steps, so that the whole 240 entry search reduces to
   // three candidates in 256 mode.
   rtpi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .in_mode   (mode_ff),
      .out_valid (link_valid[0]),
      .out_stall (link_stall[0]),
      .out_data  (link_data[0])
   );

   // A row of identical cells. Each cell scores one candidate slot against
   // the running best and hands the word to its neighbor. In 16 mode every
   // cell scores one ANSI color; in 256 mode the first three cells score the
   // cube candidate and the two gray candidates.
   for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      rtpi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .slot      (SLOT_W'(gi)),
         .in_valid  (link_valid[gi]),
         .in_stall  (link_stall[gi]),
         .in_data   (link_data[gi]),
         .out_valid (link_valid[gi+1]),
         .out_stall (link_stall[gi+1]),
         .out_data  (link_data[gi+1])
      );
   end

   // The last cell's register is the output register.
   assign link_stall[NUM_CELLS] = rsp_stall;
   assign rsp_valid             = link_valid[NUM_CELLS];
   assign rsp_palette_index     = link_data[NUM_CELLS].best_index;

   // A 16 color result always names one of the ANSI entries.
   `RTPI_ASSERT_IMPL(a_ansi_range, rsp_valid && (link_data[NUM_CELLS].mode == MODE_16), rsp_palette_index < 8'd16, "16 color result outside the ANSI range")
   // A 256 color result always lies above the ANSI entries.
   `RTPI_ASSERT_IMPL(a_cube_range, rsp_valid && (link_data[NUM_CELLS].mode == MODE_256), rsp_palette_index >= CUBE_IDX_BASE, "256 color result inside the ANSI range")
   // Back pressure at the input can only start from a held result word.
   `RTPI_ASSERT_IMPL(a_stall_origin, req_stall, rsp_valid && rsp_stall, "input stalled without a held result word")
   // A configuration write lands in the mode register on the next cycle.
   `RTPI_ASSERT_NEXT(a_mode_write, csr_write_enable, mode_ff == mode_type'($past(csr_write_data)), "mode register missed a write")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the RGB to terminal palette index core.
`timescale 1ns / 1ps

module testbench;
   import rtpi_pkg::*;

   // One pixel word as it is offered on the req channel.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_word_t;

   // Clock, reset and every input of the core start at known values.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid = 1'b0;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic       rsp_stall = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   wire  [7:0] rsp_palette_index;

   // Pixels waiting to be offered, and the palette indexes the core owes us,
   // oldest first.
   rgb_word_t  pending_pixels[$];
   logic [7:0] expected_indices[$];

   // Our own copy of the mode register, changed only while the core is idle.
   mode_type   palette_mode_copy = MODE_256;

   // Idle control for both sides. The maximum of zero gives stretches with
   // no idling at all.
   int         sender_gap_max = 3;
   int         sender_gap_left = 0;
   int         receiver_wait_max = 3;
   int         receiver_wait_left = 0;
   bit         hold_request = 1'b0;
   bit         hold_active = 1'b0;
   int         hold_left = 0;

   int         error_count = 0;
   int         pixels_256 = 0;
   int         pixels_16 = 0;
   int         results_checked = 0;
   int         stall_cycles_seen = 0;
   rgb_word_t  next_pixel;
   logic [7:0] wanted_index;

   rgb_to_terminal_palette_index_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_palette_index (rsp_palette_index)
   );

   always #2 clock = ~clock;

   // Squared Euclidean distance between the pixel and one palette color.
   function automatic int color_distance(input int r, input int g, input int b,
                                         input int pr, input int pg, input int pb);
      return (r - pr) * (r - pr) + (g - pg) * (g - pg) + (b - pb) * (b - pb);
   endfunction

   // Nearest palette index for one pixel. A strict less-than keeps the lowest
   // entry on a tie, exactly as the core is specified to do.
   function automatic logic [7:0] nearest_palette_index(input mode_type mode,
                                                        input logic [7:0] r,
                                                        input logic [7:0] g,
                                                        input logic [7:0] b);
      int levels[6];
      int best_dist;
      int best_entry;
      int entry;
      int entry_dist;
      int gray;
      int on_level;
      int pr;
      int pg;
      int pb;
      best_dist = 32'h7fffffff;
      best_entry = 0;
      if (mode == MODE_256) begin
         // Cube levels are 0 for the first step and 40 * n + 55 above it.
         for (int n = 0; n < 6; n++) begin
            levels[n] = (n == 0) ? 0 : 40 * n + 55;
         end
         entry = 0;
         for (int ir = 0; ir < 6; ir++) begin
            for (int ig = 0; ig < 6; ig++) begin
               for (int ib = 0; ib < 6; ib++) begin
                  entry_dist = color_distance(r, g, b, levels[ir], levels[ig],
                                              levels[ib]);
                  if (entry_dist < best_dist) begin
                     best_dist = entry_dist;
                     best_entry = entry;
                  end
                  entry++;
               end
            end
         end
         // All 24 grays from 8 up to 238 in steps of 10.
         for (int k = 0; k < 24; k++) begin
            gray = 8 + 10 * k;
            entry_dist = color_distance(r, g, b, gray, gray, gray);
            if (entry_dist < best_dist) begin
               best_dist = entry_dist;
               best_entry = entry;
            end
            entry++;
         end
         return 8'(best_entry + 16);
      end else begin
         for (int i = 0; i < 16; i++) begin
            on_level = i[3] ? 8'hff : 8'h80;
            pr = i[0] ? on_level : 0;
            pg = i[1] ? on_level : 0;
            pb = i[2] ? on_level : 0;
            // Slot seven is the light gray and slot eight the dark gray.
            if (i == 7) begin
               pr = 8'hc0;
               pg = 8'hc0;
               pb = 8'hc0;
            end else if (i == 8) begin
               pr = 8'h80;
               pg = 8'h80;
               pb = 8'h80;
            end
            entry_dist = color_distance(r, g, b, pr, pg, pb);
            if (entry_dist < best_dist) begin
               best_dist = entry_dist;
               best_entry = i;
            end
         end
         return 8'(best_entry);
      end
   endfunction

   // Pixel driver. A word that is offered stays put until the core takes it.
   // The prediction is made at the edge where the word is accepted, with the
   // mode that the core samples into the word at that same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_indices.push_back(nearest_palette_index(palette_mode_copy,
                                                             req_red, req_green,
                                                             req_blue));
            if (palette_mode_copy == MODE_256) begin
               pixels_256++;
            end else begin
               pixels_16++;
            end
         end
         if (req_valid && req_stall) begin
            stall_cycles_seen++;
         end
         if (!req_valid || !req_stall) begin
            if (sender_gap_left > 0) begin
               sender_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               next_pixel = pending_pixels.pop_front();
               req_red <= next_pixel.red;
               req_green <= next_pixel.green;
               req_blue <= next_pixel.blue;
               req_valid <= 1'b1;
               sender_gap_left = $urandom_range(0, sender_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the receiver. The stretch is counted here and the
   // result monitor stalls for as long as it is active.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         hold_active <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold_active <= 1'b1;
         end else begin
            hold_active <= 1'b0;
         end
      end
   end

   // Result monitor. It checks each accepted result word against the oldest
   // expected index and then draws how long to stall before the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         receiver_wait_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_indices.size() == 0) begin
               $display("%0t: result word %0d arrived with no pixel waiting",
                        $time, rsp_palette_index);
               error_count++;
            end else begin
               wanted_index = expected_indices.pop_front();
               results_checked++;
               if (rsp_palette_index !== wanted_index) begin
                  $display("%0t: palette_index mismatch, expected %0d, actual %0d",
                           $time, wanted_index, rsp_palette_index);
                  error_count++;
               end
            end
            receiver_wait_left = $urandom_range(0, receiver_wait_max);
         end
         if (hold_active) begin
            rsp_stall <= 1'b1;
         end else if (receiver_wait_left > 0) begin
            receiver_wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_pixel(input int r, input int g, input int b);
      rgb_word_t word;
      word.red = 8'(r);
      word.green = 8'(g);
      word.blue = 8'(b);
      pending_pixels.push_back(word);
   endtask

   // Edge cases: the black and white corners, the pure primaries, the two
   // replaced ANSI grays, both ends of the gray ramp, and values that sit
   // exactly between two palette colors so that the lower entry must win.
   task automatic queue_directed_pixels();
      queue_pixel(0, 0, 0);
      queue_pixel(255, 255, 255);
      queue_pixel(255, 0, 0);
      queue_pixel(0, 255, 0);
      queue_pixel(0, 0, 255);
      queue_pixel(128, 0, 0);
      queue_pixel(0, 128, 128);
      queue_pixel(192, 192, 192);
      queue_pixel(128, 128, 128);
      queue_pixel(8, 8, 8);
      queue_pixel(238, 238, 238);
      queue_pixel(243, 243, 243);
      queue_pixel(233, 233, 233);
      queue_pixel(115, 115, 115);
      queue_pixel(115, 0, 0);
      queue_pixel(47, 48, 47);
      queue_pixel(64, 64, 64);
      queue_pixel(224, 224, 224);
      queue_pixel(160, 160, 160);
      queue_pixel(255, 128, 0);
      queue_pixel(4, 4, 4);
      queue_pixel(250, 3, 130);
   endtask

   // Random pixels. Most are uniform over the whole space; the rest cluster
   // near the gray axis or near the cube decision points, where the search
   // is most likely to go wrong.
   task automatic queue_random_pixels(input int count);
      int edges[12] = '{0, 47, 48, 115, 116, 155, 156, 195, 196, 235, 236, 255};
      int pick;
      int base;
      int ch[3];
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
         end else begin
            base = $urandom_range(0, 255);
            for (int c = 0; c < 3; c++) begin
               if (pick >= 8) begin
                  base = edges[$urandom_range(0, 11)];
               end
               ch[c] = base + $urandom_range(0, 12) - 6;
               if (ch[c] < 0) begin
                  ch[c] = 0;
               end else if (ch[c] > 255) begin
                  ch[c] = 255;
               end
            end
            queue_pixel(ch[0], ch[1], ch[2]);
         end
      end
   endtask

   // The mode register is written only while the core holds no word.
   task automatic write_palette_mode(input mode_type mode);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      palette_mode_copy = mode;
   endtask

   // Waits until every queued pixel went in and every result came back,
   // then gives the pipeline a few more cycles.
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_indices.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels first in the reset mode, then in 16-color mode.
      @(negedge clock);
      queue_directed_pixels();
      wait_for_drain();
      write_palette_mode(MODE_16);
      @(negedge clock);
      queue_directed_pixels();
      wait_for_drain();

      // Random pixels with idling on both sides.
      write_palette_mode(MODE_256);
      @(negedge clock);
      queue_random_pixels(300);
      wait_for_drain();

      // The receiver holds off for a long stretch while the sender keeps
      // offering, so the pipeline fills up and stalls its input.
      write_palette_mode(MODE_16);
      @(negedge clock);
      hold_request = 1'b1;
      queue_random_pixels(300);
      wait_for_drain();

      // Full-rate stretches with no idling in either mode.
      sender_gap_max = 0;
      receiver_wait_max = 0;
      write_palette_mode(MODE_256);
      @(negedge clock);
      queue_random_pixels(150);
      wait_for_drain();
      write_palette_mode(MODE_16);
      @(negedge clock);
      queue_random_pixels(150);
      wait_for_drain();

      // Let anything left in the pipeline show up before judging.
      repeat (24) @(posedge clock);
      if (expected_indices.size() != 0) begin
         $display("%0t: %0d expected palette indexes never arrived",
                  $time, expected_indices.size());
         error_count++;
      end

      $display("Converted %0d pixels in 256-color mode and %0d in 16-color mode,",
               pixels_256, pixels_16);
      $display("checked %0d result words, input held back on %0d cycles.",
               results_checked, stall_cycles_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
